@@ hdl/sspq_pkg.sv @@
// Package for the stable sorted priority queue.
// Holds operation codes and the control struct shared by the top level and the cells.
// No dependencies.
package sspq_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_NOP  = 2'd2;

    // Broadcast control for one update of the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ hdl/sspq_cell.sv @@
// One slot of the sorted queue: holds an (id, priority) pair and trades with its neighbours.
// Depends on sspq_pkg.
module sspq_cell
    import sspq_pkg::*;
#(
    parameter int INDEX          = 0,
    parameter int PRIORITY_WIDTH = 8,
    parameter int ID_WIDTH       = 8,
    parameter int COUNT_WIDTH    = 5
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [COUNT_WIDTH-1:0]    count,
    input  logic [PRIORITY_WIDTH-1:0] new_prio,
    input  logic [ID_WIDTH-1:0]       new_id,
    input  logic                      left_keep,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic [ID_WIDTH-1:0]       left_id,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    input  logic [ID_WIDTH-1:0]       right_id,
    output logic                      keep,
    output logic [PRIORITY_WIDTH-1:0] prio,
    output logic [ID_WIDTH-1:0]       id
);

    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;
    logic [ID_WIDTH-1:0]       id_reg, id_next;
    logic                      occupied;

    // Slot holds a live item while its index lies below the count
    assign occupied = count > COUNT_WIDTH'(INDEX);
    // Keep the held item on a push when it ranks equal or higher
    assign keep     = occupied && (prio_reg >= new_prio);

    // Hold, insert, shift towards the tail on push, or shift towards the head on pop
    always_comb
    begin
        prio_next = prio_reg;
        id_next   = id_reg;
        if (ctrl.push && !keep)
        begin
            if (left_keep)
            begin
                prio_next = new_prio;
                id_next   = new_id;
            end
            else
            begin
                prio_next = left_prio;
                id_next   = left_id;
            end
        end
        else if (ctrl.pop)
        begin
            prio_next = right_prio;
            id_next   = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        id_reg   <= id_next;
    end

    assign prio = prio_reg;
    assign id   = id_reg;

endmodule

@@ hdl/stable_sorted_priority_queue.sv @@
// Top level of the stable sorted priority queue: chain of sspq_cell slots plus count and result.
// Depends on sspq_pkg and sspq_cell.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  command   operation, priority_req, entry_id       start high, busy low
//  result    head_valid, head_priority, head_id,     done strobe, one cycle
//            count, is_empty, error
//
// Every slot compares against the pushed priority and moves in the same cycle,
// so an item is taken at every clock edge; busy stays low.
// The result for an item appears in the cycle after acceptance, with done high for one cycle.
// Reset clears the count, the strobe and the error flag; slot contents are left as they are.
// The receiver cannot stall, so results are never held back.
module stable_sorted_priority_queue
    import sspq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int PRIORITY_WIDTH = 8,
    parameter int ID_WIDTH       = 8,
    parameter int COUNT_WIDTH    = $clog2(CAPACITY + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                operation,
    input  logic [PRIORITY_WIDTH-1:0] priority_req,
    input  logic [ID_WIDTH-1:0]       entry_id,
    output logic                      done,
    output logic                      head_valid,
    output logic [PRIORITY_WIDTH-1:0] head_priority,
    output logic [ID_WIDTH-1:0]       head_id,
    output logic [COUNT_WIDTH-1:0]    count,
    output logic                      is_empty,
    output logic                      error
);

    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic                      done_reg, done_next;
    logic                      error_reg, error_next;
    logic                      accept, full, empty;
    cell_ctrl_t                ctrl;

    logic                      keep_w [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] prio_w [CAPACITY];
    logic [ID_WIDTH-1:0]       id_w   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = count_reg == COUNT_WIDTH'(CAPACITY);
    assign empty  = count_reg == '0;

    // Decode the item; drop a push on full and a pop on empty
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        error_next = error_reg;
        done_next  = accept;
        if (accept)
        begin
            error_next = 1'b0;
            case (operation)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            error_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            error_reg <= error_next;
        end
    end

    // Build the slot chain, head at index zero
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                      left_keep;
            logic [PRIORITY_WIDTH-1:0] left_prio, right_prio;
            logic [ID_WIDTH-1:0]       left_id, right_id;

            if (g == 0)
            begin : g_head
                assign left_keep = 1'b1;
                assign left_prio = priority_req;
                assign left_id   = entry_id;
            end
            else
            begin : g_body
                assign left_keep = keep_w[g-1];
                assign left_prio = prio_w[g-1];
                assign left_id   = id_w[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_prio = prio_w[g];
                assign right_id   = id_w[g];
            end
            else
            begin : g_inner
                assign right_prio = prio_w[g+1];
                assign right_id   = id_w[g+1];
            end

            sspq_cell #(
                .INDEX          (g),
                .PRIORITY_WIDTH (PRIORITY_WIDTH),
                .ID_WIDTH       (ID_WIDTH),
                .COUNT_WIDTH    (COUNT_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .new_prio   (priority_req),
                .new_id     (entry_id),
                .left_keep  (left_keep),
                .left_prio  (left_prio),
                .left_id    (left_id),
                .right_prio (right_prio),
                .right_id   (right_id),
                .keep       (keep_w[g]),
                .prio       (prio_w[g]),
                .id         (id_w[g])
            );
        end
    endgenerate

    // Present the head and status after the update
    assign done          = done_reg;
    assign head_valid    = !empty;
    assign head_priority = empty ? '0 : prio_w[0];
    assign head_id       = empty ? '0 : id_w[0];
    assign count         = count_reg;
    assign is_empty      = empty;
    assign error         = error_reg;

endmodule
